/* hw/rtl/kvfe_pkg.sv */
// Shared types and constants of the key/value field extractor.
`timescale 1ns / 1ps

package kvfe_pkg;

	localparam int unsigned CNT_W = 7;   // captured-byte counter, covers caps up to 127
	localparam int unsigned ACC_W = 32;  // magnitude, saturates at 2^31

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [ACC_W-1:0] MAG_LIMIT = 32'h8000_0000;
	localparam logic [ACC_W-1:0] POS_MAX   = 32'h7FFF_FFFF;

	// register byte addresses
	localparam logic [3:0] ADDR_KEY_TEXT   = 4'h0;
	localparam logic [3:0] ADDR_KEY_LENGTH = 4'h8;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_COLON,
		PH_CAPTURE,
		PH_FINISHED
	} kvfe_phase_t;

	typedef enum logic [1:0] {
		NS_SPACE,
		NS_DIGITS,
		NS_STOPPED
	} kvfe_nstage_t;

	// control from the sequencer to the number parser
	typedef struct packed {
		logic feed;      // parse this byte
		logic clr_pre;   // clear before the byte (colon seen)
		logic clr_post;  // clear after the byte (rearm)
	} kvfe_num_cmd_t;

	typedef struct packed {
		logic              has_byte;
		logic [7:0]        value_byte;
		logic              done_res;
		logic              found;
		logic signed [31:0] number;
	} kvfe_res_t;

endpackage

/* hw/rtl/kvfe_win_cell.sv */
// Key window cell: holds one message byte and compares byte_in with its key byte.
`timescale 1ns / 1ps

module kvfe_win_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic       clear,
	input  logic [7:0] byte_in,
	input  logic       vld_in,
	input  logic [7:0] key_byte,
	input  logic       active,
	output logic [7:0] byte_q,
	output logic       vld_q,
	output logic       hit
);

	// compare against the byte arriving in this cycle
	assign hit = !active || (vld_in && (byte_in == key_byte));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (clear) begin
			vld_q <= 1'b0;
		end else if (shift) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= byte_in;
		end
	end

endmodule

/* hw/rtl/kvfe_num_parser.sv */
// atoi-style value parser: whitespace, sign, saturating decimal accumulate.
`timescale 1ns / 1ps

module kvfe_num_parser
	import kvfe_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  kvfe_num_cmd_t      cmd,
	input  logic [7:0]         data_byte,
	output logic signed [31:0] number
);

	logic [ACC_W-1:0] acc_q, acc_in, acc_n;
	logic             neg_q, neg_in, neg_n;
	kvfe_nstage_t     stage_q, stage_in, stage_n;

	logic             is_digit, is_space, is_sign;
	logic [3:0]       digit;
	logic [ACC_W+3:0] prod;
	logic [ACC_W-1:0] mag;

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_space = (data_byte == CH_SPACE) || ((data_byte >= CH_TAB) && (data_byte <= CH_CR));
	assign is_sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);
	assign digit    = 4'(data_byte - CH_ZERO);

	// acc * 10 + digit
	assign prod = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0} + {{ACC_W{1'b0}}, digit};

	always_comb begin
		acc_in   = cmd.clr_pre ? '0 : acc_q;
		neg_in   = cmd.clr_pre ? 1'b0 : neg_q;
		stage_in = cmd.clr_pre ? NS_SPACE : stage_q;
		acc_n    = acc_in;
		neg_n    = neg_in;
		stage_n  = stage_in;
		if (cmd.feed) begin
			case (stage_in)
				NS_SPACE: begin
					if (is_space) begin
						stage_n = NS_SPACE;
					end else if (is_sign) begin
						neg_n   = (data_byte == CH_MINUS);
						stage_n = NS_DIGITS;
					end else if (is_digit) begin
						stage_n = NS_DIGITS;
						acc_n   = (prod > {4'b0000, MAG_LIMIT}) ? MAG_LIMIT : prod[ACC_W-1:0];
					end else begin
						stage_n = NS_STOPPED;
					end
				end
				NS_DIGITS: begin
					if (is_digit) begin
						acc_n = (prod > {4'b0000, MAG_LIMIT}) ? MAG_LIMIT : prod[ACC_W-1:0];
					end else begin
						stage_n = NS_STOPPED;
					end
				end
				default: begin
					stage_n = stage_in;
				end
			endcase
		end
	end

	assign mag    = (acc_n > POS_MAX) ? POS_MAX : acc_n;
	assign number = neg_n ? signed'(32'(0) - acc_n) : signed'(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			neg_q   <= 1'b0;
			stage_q <= NS_SPACE;
		end else if (en) begin
			if (cmd.clr_post) begin
				acc_q   <= '0;
				neg_q   <= 1'b0;
				stage_q <= NS_SPACE;
			end else begin
				acc_q   <= acc_n;
				neg_q   <= neg_n;
				stage_q <= stage_n;
			end
		end
	end

endmodule

/* hw/rtl/key_value_field_extractor_unit.sv */
// Top level of the key/value field extractor: window cells, sequencer, output skid.
`timescale 1ns / 1ps

// Takes one message byte per clock on the slave stream (tlast marks the last byte of a
// message) and looks for the configured key in a row of KEY_MAX_LEN window cells, each
// holding one recent byte and comparing the byte entering it with its key byte. After
// the key the first ':' opens the value; value bytes go out one per cycle with tuser set,
// until ',' or '.', the end of the message, or VALUE_CAP bytes. The final result carries
// tlast, the found flag and the saturated atoi value of the captured bytes. Each byte is
// decided in the cycle it is accepted and its result is registered, so the block sustains
// one byte per clock while results are taken. A second output entry takes one more result
// while the master stalls; s_tready drops only once two results are waiting. Registers:
// key_text at byte address 0 (64 bits, last key character in bits 7:0), key_length at 8.
module key_value_field_extractor_unit
	import kvfe_pkg::*;
#(
	parameter int unsigned KEY_MAX_LEN = 8,
	parameter int unsigned VALUE_CAP   = 99
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_message
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] value_byte, [8] found, [40:9] number, [47:41] zero
	output logic        m_tlast,   // done_res
	output logic        m_tuser,   // has_byte
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam logic [3:0]       KeyMax = 4'(KEY_MAX_LEN);
	localparam logic [CNT_W-1:0] Cap    = CNT_W'(VALUE_CAP);

	logic        accept;
	logic [7:0]  b;
	logic        eom;

	logic [63:0] key_text_q;
	logic [3:0]  key_length_q;
	logic [3:0]  len;

	kvfe_phase_t      phase_q, phase_n;
	logic [CNT_W-1:0] cnt_q, cnt_n, cnt_inc;

	logic [KEY_MAX_LEN-1:0] hit;
	logic [7:0]             cell_byte [KEY_MAX_LEN];
	logic [KEY_MAX_LEN-1:0] cell_vld;
	logic                   key_hit;

	logic has, done, fnd, chk, colon_hit, shift, rearm, delim;
	kvfe_num_cmd_t      ncmd;
	logic signed [31:0] num;
	kvfe_res_t          res;

	logic      out_vld_q, skid_vld_q, push, pop;
	kvfe_res_t out_q, skid_q;

	assign b      = s_tdata;
	assign eom    = s_tlast;
	assign accept = s_tvalid && s_tready;

	// configuration port
	assign pready = 1'b1;
	assign prdata = paddr[3] ? {60'd0, key_length_q} : key_text_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q   <= '0;
			key_length_q <= 4'd1;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[3] == ADDR_KEY_LENGTH[3]) begin
				key_length_q <= pwdata[3:0];
			end else begin
				key_text_q <= pwdata;
			end
		end
	end

	assign len = (key_length_q > KeyMax) ? KeyMax : key_length_q;

	// key window
	for (genvar i = 0; i < KEY_MAX_LEN; i++) begin : g_cell
		logic [7:0] bin;
		logic       vin;
		if (i == 0) begin : g_head
			assign bin = b;
			assign vin = 1'b1;
		end else begin : g_link
			assign bin = cell_byte[i-1];
			assign vin = cell_vld[i-1];
		end
		kvfe_win_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    (accept && shift),
			.clear    (accept && rearm),
			.byte_in  (bin),
			.vld_in   (vin),
			.key_byte (key_text_q[8*i +: 8]),
			.active   (4'(i) < len),
			.byte_q   (cell_byte[i]),
			.vld_q    (cell_vld[i]),
			.hit      (hit[i])
		);
	end

	assign key_hit   = &hit;
	assign delim     = (b == CH_COMMA) || (b == CH_DOT);
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign colon_hit = chk && (b == CH_COLON);

	// per-byte decode
	always_comb begin
		has   = 1'b0;
		done  = 1'b0;
		fnd   = 1'b0;
		chk   = 1'b0;
		shift = 1'b0;
		rearm = 1'b0;
		case (phase_q)
			PH_FINISHED: begin
				rearm = eom;
			end
			PH_COLON: begin
				chk = 1'b1;
			end
			PH_CAPTURE: begin
				if (delim) begin
					done = 1'b1;
					fnd  = 1'b1;
				end else begin
					has = 1'b1;
					if (cnt_inc >= Cap) begin
						done = 1'b1;
						fnd  = 1'b1;
					end
				end
			end
			PH_SEARCH: begin
				shift = 1'b1;
				chk   = (len == 4'd0);
			end
			default: begin
				rearm = 1'b1;
			end
		endcase
		if (phase_q != PH_FINISHED) begin
			if (eom && !done) begin
				done = 1'b1;
				fnd  = colon_hit || (phase_q == PH_CAPTURE);
			end
			if (done && eom) begin
				rearm = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		case (phase_q)
			PH_CAPTURE: begin
				if (has) begin
					cnt_n = cnt_inc;
				end
			end
			PH_SEARCH: begin
				if (len == 4'd0 || key_hit) begin
					phase_n = PH_COLON;
				end
			end
			default: begin
				phase_n = phase_q;
			end
		endcase
		if (colon_hit) begin
			phase_n = PH_CAPTURE;
			cnt_n   = '0;
		end
		if (done) begin
			phase_n = PH_FINISHED;
		end
		if (rearm) begin
			phase_n = PH_SEARCH;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			cnt_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
		end
	end

	assign ncmd.feed     = has;
	assign ncmd.clr_pre  = colon_hit;
	assign ncmd.clr_post = rearm;

	kvfe_num_parser u_num (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (accept),
		.cmd       (ncmd),
		.data_byte (b),
		.number    (num)
	);

	assign res.has_byte   = has;
	assign res.value_byte = has ? b : 8'd0;
	assign res.done_res   = done;
	assign res.found      = fnd;
	assign res.number     = fnd ? num : 32'sd0;

	// output register with skid entry
	assign push     = accept && (has || done);
	assign pop      = out_vld_q && m_tready;
	assign s_tready = !skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, out_q.number, out_q.found, out_q.value_byte};
	assign m_tlast  = out_q.done_res;
	assign m_tuser  = out_q.has_byte;

endmodule

/* dv/kvfe_field_checker.sv */
// Stream and register monitor for the key/value field extractor, with its own prediction of each result.
`timescale 1ns / 1ps

module kvfe_field_checker
	import kvfe_pkg::*;
#(
	parameter int unsigned KEY_MAX_LEN = 8,
	parameter int unsigned VALUE_CAP   = 99
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_message
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [47:0] m_tdata,   // [7:0] value_byte, [8] found, [40:9] number, [47:41] zero
	input  logic        m_tlast,   // done_res
	input  logic        m_tuser,   // has_byte
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          outstanding
);

	// register copies
	logic [63:0] key_text;
	logic [3:0]  key_length;

	// extractor state
	logic [63:0]  window;
	int unsigned  window_fill;
	kvfe_phase_t  phase;
	logic [6:0]   captured;
	logic [31:0]  magnitude;
	logic         negative;
	kvfe_nstage_t stage;

	kvfe_res_t due_results[$];
	int fails = 0;
	int pending_n = 0;

	assign mismatches  = fails;
	assign outstanding = pending_n;

	function automatic void clear_value();
		captured  = '0;
		magnitude = '0;
		negative  = 1'b0;
		stage     = NS_SPACE;
	endfunction

	function automatic void rearm_search();
		window      = '0;
		window_fill = 0;
		phase       = PH_SEARCH;
		clear_value();
	endfunction

	// atoi on one value character: whitespace, optional sign, then digits
	function automatic void parse_char(input logic [7:0] c);
		logic        is_digit;
		logic [35:0] acc;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		if (stage == NS_SPACE) begin
			if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
				return;
			if (c == CH_PLUS || c == CH_MINUS) begin
				negative = (c == CH_MINUS);
				stage    = NS_DIGITS;
				return;
			end
			stage = is_digit ? NS_DIGITS : NS_STOPPED;
		end
		if (stage != NS_DIGITS)
			return;
		if (!is_digit) begin
			stage = NS_STOPPED;
			return;
		end
		acc = {4'd0, magnitude} * 36'd10 + 36'(c - CH_ZERO);
		magnitude = (acc > 36'(MAG_LIMIT)) ? MAG_LIMIT : acc[31:0];
	endfunction

	function automatic void extract_step(input logic [7:0] b, input logic eom);
		logic        has, done, fnd, look_colon;
		int unsigned n;
		logic [63:0] mask;
		logic [31:0] num_bits;
		kvfe_res_t   r;
		has = 1'b0;
		done = 1'b0;
		fnd = 1'b0;
		look_colon = 1'b0;
		num_bits = '0;
		if (phase == PH_FINISHED) begin
			if (eom)
				rearm_search();
			return;
		end
		if (phase == PH_COLON) begin
			look_colon = 1'b1;
		end else if (phase == PH_CAPTURE) begin
			if (b == CH_COMMA || b == CH_DOT) begin
				done = 1'b1;
				fnd  = 1'b1;
			end else begin
				has = 1'b1;
				parse_char(b);
				captured = captured + 7'd1;
				if (captured >= VALUE_CAP) begin
					done = 1'b1;
					fnd  = 1'b1;
				end
			end
		end else begin
			n = (key_length > KEY_MAX_LEN) ? KEY_MAX_LEN : key_length;
			window = {window[55:0], b};
			if (window_fill < 8)
				window_fill++;
			mask = (n >= 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
			if (n == 0) begin
				phase = PH_COLON;
				look_colon = 1'b1;
			end else if (window_fill >= n && (window & mask) == (key_text & mask)) begin
				// colon search starts with the next byte, so a ':' in the key is not seen
				phase = PH_COLON;
			end
		end
		if (look_colon && b == CH_COLON) begin
			phase = PH_CAPTURE;
			clear_value();
		end
		if (eom && !done) begin
			done = 1'b1;
			fnd  = (phase == PH_CAPTURE);
		end
		if (done) begin
			if (fnd)
				num_bits = negative ? (32'd0 - magnitude) :
					((magnitude > POS_MAX) ? POS_MAX : magnitude);
			if (eom)
				rearm_search();
			else
				phase = PH_FINISHED;
		end
		if (!has && !done)
			return;
		r.has_byte   = has;
		r.value_byte = has ? b : 8'd0;
		r.done_res   = done;
		r.found      = fnd;
		r.number     = num_bits;
		due_results.push_back(r);
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kvfe_res_t want;
		if (!arst_n) begin
			key_text   = '0;
			key_length = 4'd1;
			rearm_search();
			due_results.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == ADDR_KEY_TEXT)
					key_text = pwdata;
				else if (paddr == ADDR_KEY_LENGTH)
					key_length = pwdata[3:0];
			end
			// results leave before this edge's request can add one
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					fails++;
					$display("%0t: result with nothing due, expected none, actual tdata %h tlast %b tuser %b",
						$time, m_tdata, m_tlast, m_tuser);
				end else begin
					want = due_results.pop_front();
					check_field("has_byte", 32'(want.has_byte), 32'(m_tuser));
					check_field("value_byte", 32'(want.value_byte), 32'(m_tdata[7:0]));
					check_field("done_res", 32'(want.done_res), 32'(m_tlast));
					check_field("found", 32'(want.found), 32'(m_tdata[8]));
					check_field("number", want.number, m_tdata[40:9]);
					check_field("tdata padding", 32'd0, 32'(m_tdata[47:41]));
				end
			end
			if (s_tvalid && s_tready)
				extract_step(s_tdata, s_tlast);
		end
		pending_n = due_results.size();
	end

endmodule

/* dv/key_value_field_extractor_unit_tb.sv */
// Stimulus, register set-up and verdict for the key/value field extractor.
`timescale 1ns / 1ps

module key_value_field_extractor_unit_tb
	import kvfe_pkg::*;
();

	localparam int unsigned KEY_MAX_LEN = 8;
	localparam int unsigned VALUE_CAP   = 99;
	localparam int STALL_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS  = 215;
	localparam int NUM_PHASES   = 7;

	localparam string KEY_CHARS = "akx:";
	localparam string TEXT_CHARS = "akx:z1-, .";
	localparam string FILL_CHARS = "akxz 9";

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	int          mismatches;
	int          outstanding;

	// stimulus-side copy of the key set-up
	logic [63:0] cur_key = '0;
	logic [3:0]  cur_len = 4'd1;
	logic [7:0]  msg[$];
	bit          idle_en = 1'b1;
	bit          hold_go = 1'b0;

	key_value_field_extractor_unit #(
		.KEY_MAX_LEN(KEY_MAX_LEN),
		.VALUE_CAP  (VALUE_CAP)
	) i_dut (.*);

	kvfe_field_checker #(
		.KEY_MAX_LEN(KEY_MAX_LEN),
		.VALUE_CAP  (VALUE_CAP)
	) i_checker (.*);

	always #6 clk = ~clk;

	// receiver: random back-pressure, or one long hold-off on request
	initial forever begin
		@(posedge clk);
		if (hold_go) begin
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_go = 1'b0;
		end else begin
			m_tready <= !idle_en || ($urandom_range(99) >= 35);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	function automatic logic [63:0] random_key();
		logic [63:0] k;
		for (int i = 0; i < 8; i++)
			k[8*i +: 8] = pick(KEY_CHARS);
		return k;
	endfunction

	// mostly key, colon and a value; some noise and broken keys
	function automatic void build_message();
		int kind, n, digits, r;
		msg.delete();
		kind = $urandom_range(99);
		n = (cur_len > KEY_MAX_LEN) ? KEY_MAX_LEN : cur_len;
		if (kind < 25) begin
			repeat ($urandom_range(1, 10))
				msg.push_back(($urandom_range(2) == 0) ? 8'($urandom) : pick(TEXT_CHARS));
			return;
		end
		repeat ($urandom_range(0, 3)) msg.push_back(pick(TEXT_CHARS));
		for (int i = n - 1; i >= 0; i--)
			msg.push_back(cur_key[8*i +: 8]);
		if (kind < 33 && msg.size() > 0)
			void'(msg.pop_back());
		repeat ($urandom_range(0, 2)) msg.push_back(pick(FILL_CHARS));
		msg.push_back(CH_COLON);
		repeat ($urandom_range(0, 2))
			msg.push_back($urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)));
		case ($urandom_range(3))
			0: msg.push_back(CH_PLUS);
			1: msg.push_back(CH_MINUS);
			default: ;
		endcase
		r = $urandom_range(99);
		if (r < 4)
			digits = $urandom_range(100, 105);
		else if (r < 22)
			digits = $urandom_range(9, 12);
		else
			digits = $urandom_range(0, 6);
		repeat (digits)
			msg.push_back(($urandom_range(19) == 0) ? 8'($urandom) :
				CH_ZERO + 8'($urandom_range(9)));
		case ($urandom_range(3))
			0: msg.push_back(CH_COMMA);
			1: msg.push_back(CH_DOT);
			2: ;
			default: begin
				msg.push_back(CH_COMMA);
				repeat ($urandom_range(1, 3)) msg.push_back(8'($urandom));
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idle_en)
			while ($urandom_range(99) < 35) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_message();
		foreach (msg[i])
			send_byte(msg[i], i == msg.size() - 1);
	endtask

	task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// let every due result drain, then give the block time to settle
	task automatic quiesce();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int sent;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset key is a single zero byte
		msg = {8'h00, CH_COLON, CH_MINUS, 8'h31, CH_COMMA, 8'hFF};
		send_message();
		// key only on the last byte: not found
		msg = {CH_COLON, 8'h00};
		send_message();
		// colon on the last byte
		msg = {8'h00, CH_COLON};
		send_message();
		// delimiter together with end of message
		msg = {8'h00, CH_COLON, CH_SPACE, CH_PLUS, 8'h39, CH_DOT};
		send_message();
		// zero byte inside the value stops the number
		msg = {8'h00, CH_COLON, 8'h00, 8'h35};
		send_message();

		for (int p = 0; p < NUM_PHASES; p++) begin
			quiesce();
			case (p)
				0: begin cur_key = 64'h6B; cur_len = 4'd1; end
				1: begin cur_key = random_key(); cur_len = 4'd2; end
				2: begin cur_key = '1; cur_len = 4'd8; end
				3: begin cur_key = random_key(); cur_len = 4'd0; end
				4: begin cur_key = random_key(); cur_len = 4'd15; end
				5: begin cur_key = '0; cur_len = 4'd8; end
				default: begin cur_key = random_key(); cur_len = 4'd3; end
			endcase
			reg_write(ADDR_KEY_TEXT, cur_key);
			reg_write(ADDR_KEY_LENGTH, 64'(cur_len));
			idle_en = (p != 3);
			if (p == 1)
				hold_go = 1'b1;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				build_message();
				sent += msg.size();
				send_message();
			end
		end

		quiesce();
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
